>>> rtl/sdur_pkg.sv
package sdur_pkg;

  // Fixed field widths of the two channels and the configuration port.
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 64;
  localparam int SUM_W     = 32;
  localparam int MS_W      = 16;
  localparam int ACTION_W  = 3;
  localparam int STEP_W    = 7;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 128;
  localparam int SNAP_WIDTH_DEFAULT = 64;

  // Reset value of the debounce interval in milliseconds.
  localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd500;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_UNDO  = 2'd1,
    KIND_REDO  = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_COMMIT  = 3'd1,
    ACT_FOLD    = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_REFUSE  = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_RESTORE = 1'b1
  } state_t;

endpackage

>>> rtl/sdur_in_if.sv
interface sdur_in_if;
  logic                          valid;
  logic                          ready;
  logic [sdur_pkg::KIND_W-1:0]   kind;
  logic [sdur_pkg::DATA_W-1:0]   model_data;
  logic [sdur_pkg::SUM_W-1:0]    model_sum;
  logic [sdur_pkg::MS_W-1:0]     elapsed_ms;

  modport source (output valid, output kind, output model_data, output model_sum,
                  output elapsed_ms, input ready);
  modport sink (input valid, input kind, input model_data, input model_sum,
                input elapsed_ms, output ready);
endinterface

>>> rtl/sdur_out_if.sv
interface sdur_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdur_pkg::ACTION_W-1:0] action;
  logic [sdur_pkg::DATA_W-1:0]   restored_data;
  logic [sdur_pkg::SUM_W-1:0]    restored_sum;
  logic [sdur_pkg::STEP_W-1:0]   position;
  logic [sdur_pkg::STEP_W-1:0]   undo_steps;
  logic [sdur_pkg::STEP_W-1:0]   redo_steps;

  modport source (output valid, output action, output restored_data, output restored_sum,
                  output position, output undo_steps, output redo_steps, input ready);
  modport sink (input valid, input action, input restored_data, input restored_sum,
                input position, input undo_steps, input redo_steps, output ready);
endinterface

>>> rtl/sdur_mem.sv
// Simple dual-port history memory: one write port, one registered read port.
module sdur_mem #(
  parameter int DEPTH = sdur_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = sdur_pkg::SNAP_WIDTH_DEFAULT + sdur_pkg::SUM_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/settle_debounced_undo_ring_core.sv
// Undo/redo history ring with settle debouncing.
//
// Words enter on the item channel and leave on the result channel, both
// valid/ready; a word moves at a clock edge where valid and ready are high.
// Every item yields exactly one result word, in order. The debounce interval
// is written through debounce_we/debounce_data; the user must do so only
// while the block is idle, as the block itself does not enforce this.
//
// Ticks, history resets and refused moves are answered in the cycle after
// acceptance. An undo or redo that moves first reads the synchronous history
// memory into its read register and sits in its restore state, taking no new
// item, then loads the result. Each item performs at most one memory access,
// and only one item is in flight, so no read meets a write to the same entry.
//
// The result is held in an output register; the next item is accepted in
// the same cycle the held result is taken. While the receiver stalls, the
// result stays put and no new item is accepted. Synchronous reset clears
// the control state and the counters and sets the debounce interval to
// 500 ms; the memory holds no defined contents until written.
module settle_debounced_undo_ring_core #(
  parameter int DEPTH      = sdur_pkg::DEPTH_DEFAULT,
  parameter int SNAP_WIDTH = sdur_pkg::SNAP_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  sdur_in_if.sink                     item,
  sdur_out_if.source                  result,
  input  logic                        debounce_we,
  input  logic [sdur_pkg::MS_W-1:0]   debounce_data
);

  localparam int IW     = $clog2(DEPTH);
  localparam int WORD_W = SNAP_WIDTH + sdur_pkg::SUM_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  // Ring counters are reported through a fixed seven-bit field.
  function automatic logic [sdur_pkg::STEP_W-1:0] to_step(input logic [IW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[sdur_pkg::STEP_W-1:0];
  endfunction

  sdur_pkg::state_t state, state_next;

  logic [IW-1:0]               cur_idx, cur_idx_next;
  logic [IW-1:0]               older, older_next;
  logic [IW-1:0]               newer, newer_next;
  logic [sdur_pkg::SUM_W-1:0]  cur_sum, cur_sum_next;
  logic [sdur_pkg::SUM_W-1:0]  last_sum, last_sum_next;
  logic [sdur_pkg::MS_W-1:0]   cooldown, cooldown_next;
  logic [sdur_pkg::MS_W-1:0]   debounce;

  logic                          out_valid, out_valid_next;
  sdur_pkg::action_t             out_action, out_action_next;
  logic [sdur_pkg::DATA_W-1:0]   out_data, out_data_next;
  logic [sdur_pkg::SUM_W-1:0]    out_sum, out_sum_next;
  logic [sdur_pkg::STEP_W-1:0]   out_pos, out_pos_next;
  logic [sdur_pkg::STEP_W-1:0]   out_undo, out_undo_next;
  logic [sdur_pkg::STEP_W-1:0]   out_redo, out_redo_next;

  logic                in_ready;
  logic                accept;
  logic                out_load;
  logic [IW-1:0]       idx_inc, idx_dec;
  logic [sdur_pkg::MS_W-1:0] cd_left;
  sdur_pkg::kind_t     kind;

  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;

  sdur_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign kind    = sdur_pkg::kind_t'(item.kind);
  assign idx_inc = (cur_idx == LAST) ? '0 : cur_idx + 1'b1;
  assign idx_dec = (cur_idx == '0) ? LAST : cur_idx - 1'b1;
  assign cd_left = (cooldown > item.elapsed_ms) ? cooldown - item.elapsed_ms : '0;

  // Every write stores the live snapshot of the accepted item.
  assign mem_wdata = {item.model_sum, item.model_data[SNAP_WIDTH-1:0]};

  assign in_ready   = (state == sdur_pkg::ST_IDLE) && (!out_valid || result.ready);
  assign accept     = item.valid && in_ready;
  assign item.ready = in_ready;

  always_comb begin
    state_next    = state;
    cur_idx_next  = cur_idx;
    older_next    = older;
    newer_next    = newer;
    cur_sum_next  = cur_sum;
    last_sum_next = last_sum;
    cooldown_next = cooldown;
    mem_we        = 1'b0;
    mem_waddr     = cur_idx;
    mem_re        = 1'b0;
    mem_raddr     = cur_idx;
    out_load      = 1'b0;
    out_action_next = sdur_pkg::ACT_NONE;
    out_data_next   = '0;
    out_sum_next    = '0;

    unique case (state)
      sdur_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            sdur_pkg::KIND_RESET: begin
              mem_we        = 1'b1;
              mem_waddr     = '0;
              cur_idx_next  = '0;
              older_next    = '0;
              newer_next    = '0;
              cur_sum_next  = item.model_sum;
              last_sum_next = item.model_sum;
              cooldown_next = '0;
              out_load      = 1'b1;
            end
            sdur_pkg::KIND_UNDO: begin
              if (older == '0) begin
                out_load        = 1'b1;
                out_action_next = sdur_pkg::ACT_REFUSE;
              end else begin
                cur_idx_next = idx_dec;
                older_next   = older - 1'b1;
                newer_next   = newer + 1'b1;
                mem_re       = 1'b1;
                mem_raddr    = idx_dec;
                state_next   = sdur_pkg::ST_RESTORE;
              end
            end
            sdur_pkg::KIND_REDO: begin
              if (newer == '0) begin
                out_load        = 1'b1;
                out_action_next = sdur_pkg::ACT_REFUSE;
              end else begin
                cur_idx_next = idx_inc;
                newer_next   = newer - 1'b1;
                older_next   = older + 1'b1;
                mem_re       = 1'b1;
                mem_raddr    = idx_inc;
                state_next   = sdur_pkg::ST_RESTORE;
              end
            end
            sdur_pkg::KIND_TICK: begin
              out_load      = 1'b1;
              cooldown_next = cd_left;
              priority if (item.model_sum == cur_sum || item.model_sum != last_sum) begin
                // Unchanged, or still moving: only remember what was seen.
                last_sum_next = item.model_sum;
              end else if (cd_left != '0) begin
                // Settled inside the debounce window: overwrite current entry.
                mem_we          = 1'b1;
                mem_waddr       = cur_idx;
                cur_sum_next    = item.model_sum;
                out_action_next = sdur_pkg::ACT_FOLD;
              end else begin
                // Settled and the window has run out: commit a fresh entry.
                mem_we          = 1'b1;
                mem_waddr       = idx_inc;
                cur_idx_next    = idx_inc;
                newer_next      = '0;
                older_next      = (older < LAST) ? older + 1'b1 : LAST;
                cur_sum_next    = item.model_sum;
                last_sum_next   = item.model_sum;
                cooldown_next   = debounce;
                out_action_next = sdur_pkg::ACT_COMMIT;
              end
            end
          endcase
        end
      end
      sdur_pkg::ST_RESTORE: begin
        // The read issued on acceptance has landed in mem_rdata.
        cur_sum_next    = mem_rdata[WORD_W-1:SNAP_WIDTH];
        last_sum_next   = mem_rdata[WORD_W-1:SNAP_WIDTH];
        cooldown_next   = '0;
        out_load        = 1'b1;
        out_action_next = sdur_pkg::ACT_RESTORE;
        out_data_next   = sdur_pkg::DATA_W'(mem_rdata[SNAP_WIDTH-1:0]);
        out_sum_next    = mem_rdata[WORD_W-1:SNAP_WIDTH];
        state_next      = sdur_pkg::ST_IDLE;
      end
    endcase

    out_pos_next  = to_step(cur_idx_next);
    out_undo_next = to_step(older_next);
    out_redo_next = to_step(newer_next);

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdur_pkg::ST_IDLE;
      cur_idx   <= '0;
      older     <= '0;
      newer     <= '0;
      cur_sum   <= '0;
      last_sum  <= '0;
      cooldown  <= '0;
      debounce  <= sdur_pkg::DEBOUNCE_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_idx   <= cur_idx_next;
      older     <= older_next;
      newer     <= newer_next;
      cur_sum   <= cur_sum_next;
      last_sum  <= last_sum_next;
      cooldown  <= cooldown_next;
      out_valid <= out_valid_next;
      if (debounce_we) begin
        debounce <= debounce_data;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_action <= out_action_next;
      out_data   <= out_data_next;
      out_sum    <= out_sum_next;
      out_pos    <= out_pos_next;
      out_undo   <= out_undo_next;
      out_redo   <= out_redo_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.action        = out_action;
  assign result.restored_data = out_data;
  assign result.restored_sum  = out_sum;
  assign result.position      = out_pos;
  assign result.undo_steps    = out_undo;
  assign result.redo_steps    = out_redo;

endmodule
